>>> sv/tcbgp_pkg.sv
// Shared types and constants for the two-colour block glyph picker.
// No dependencies; imported by tcbgp_core and the top level.
package tcbgp_pkg;

    localparam int unsigned CellPixels  = 4;
    localparam int unsigned NumColours  = 8;
    localparam int unsigned PenWidth    = 4;
    localparam int unsigned ColourWidth = 3;
    localparam int unsigned CountWidth  = 3;

    localparam logic [ColourWidth-1:0] SolidSplit   = 3'd5;
    localparam logic [ColourWidth-1:0] WhiteColour  = 3'd7;
    localparam logic [ColourWidth-1:0] BlackColour  = 3'd0;
    localparam logic [CountWidth-1:0]  FullCount    = 3'd4;

    typedef logic [PenWidth-1:0]    t_pen;
    typedef logic [ColourWidth-1:0] t_colour;
    typedef logic [CountWidth-1:0]  t_count;

    // Pens of one cell: index 0 top-left .. 3 bottom-right
    typedef t_pen [CellPixels-1:0] t_cell_pens;

    typedef struct packed {
        t_colour                paper_colour;
        t_colour                ink_colour;
        logic                   bright_flag;
        logic                   attributes_present;
        logic [CellPixels-1:0]  glyph_mask;
    } t_cell_result;

endpackage

>>> sv/two_colour_block_glyph_picker.sv
// Top level: input register, cell reduction, result register, mono_mode register.
// Depends on tcbgp_pkg and tcbgp_core.
//
// Takes one 2x2 cell per clock while i_ready stays high and returns one result
// per cell, in order. A request goes into the input register on acceptance,
// passes through the combinational reduction in tcbgp_core, and lands in the
// result register, where it is presented on o_valid and held until taken; the
// two register stages, input and result, lie between acceptance and o_valid.
// Sustained rate is one cell per cycle while i_ready stays high. Each register
// stage advances whenever the stage after it is empty or moving, and o_ready
// follows i_ready combinationally through that chain. The mono_mode register is
// written with i_cfg_wr_en / i_cfg_wr_data and should only change while no
// request is in flight.
module two_colour_block_glyph_picker
    import tcbgp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,

    input  logic    i_cfg_wr_en,
    input  logic    i_cfg_wr_data,

    input  logic    i_valid,
    output logic    o_ready,
    input  t_pen    i_pen_top_left,
    input  t_pen    i_pen_top_right,
    input  t_pen    i_pen_bottom_left,
    input  t_pen    i_pen_bottom_right,

    output logic    o_valid,
    input  logic    i_ready,
    output t_colour o_paper_colour,
    output t_colour o_ink_colour,
    output logic    o_bright_flag,
    output logic    o_attributes_present,
    output logic [CellPixels-1:0] o_glyph_mask
);

    logic         r_mono_mode;
    logic         r_in_valid;
    t_cell_pens   r_pens;
    logic         r_out_valid;
    t_cell_result r_out;
    t_cell_result w_result;
    logic         w_out_adv;
    logic         w_in_adv;

    // Advance each stage when the next one is empty or draining
    assign w_out_adv = ~r_out_valid | i_ready;
    assign w_in_adv  = ~r_in_valid | w_out_adv;
    assign o_ready   = w_in_adv;

    // Hold the mono_mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mono_mode <= i_cfg_wr_data;
        end
    end

    // Capture an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_valid) begin
            r_pens[0] <= i_pen_top_left;
            r_pens[1] <= i_pen_top_right;
            r_pens[2] <= i_pen_bottom_left;
            r_pens[3] <= i_pen_bottom_right;
        end
    end

    tcbgp_core u_core (
        .i_pens      (r_pens),
        .i_mono_mode (r_mono_mode),
        .o_result    (w_result)
    );

    // Register the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_in_valid) begin
            r_out <= w_result;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_paper_colour       = r_out.paper_colour;
    assign o_ink_colour         = r_out.ink_colour;
    assign o_bright_flag        = r_out.bright_flag;
    assign o_attributes_present = r_out.attributes_present;
    assign o_glyph_mask         = r_out.glyph_mask;

`ifndef NO_ASSERTIONS
    // Ink never sits above paper
    a_ink_le_paper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_ink_colour <= o_paper_colour)
        else $error("ink colour above paper colour");

    // Mono results carry no colour
    a_mono_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_attributes_present) |->
        (o_paper_colour == BlackColour && o_ink_colour == BlackColour && !o_bright_flag))
        else $error("colour attributes leaked in mono mode");

    // Equal ink and paper only happens for black
    a_equal_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_attributes_present && o_ink_colour == o_paper_colour) |->
        o_ink_colour == BlackColour)
        else $error("ink equals paper on a non-black colour");

    // An accepted request always occupies the input stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_in_valid)
        else $error("accepted request lost at input stage");

    // A blocked input stage keeps its request
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_adv) |=> r_in_valid)
        else $error("stalled request dropped from input stage");
`endif

endmodule

>>> sv/tcbgp_core.sv
// Combinational reduction of one 2x2 cell to ink, paper, bright flag and glyph.
// Depends on tcbgp_pkg.
module tcbgp_core
    import tcbgp_pkg::*;
(
    input  t_cell_pens   i_pens,
    input  logic         i_mono_mode,
    output t_cell_result o_result
);

    function automatic t_colour colour_distance(t_colour a, t_colour b);
        colour_distance = (a > b) ? (a - b) : (b - a);
    endfunction

    t_colour [CellPixels-1:0] w_colour;
    t_colour [CellPixels-1:0] w_moved;
    t_count  [NumColours-1:0] w_count;
    t_count                   w_n_bright;
    t_count                   w_n_plain;
    t_colour                  w_first;
    t_colour                  w_second;
    t_colour                  w_ink;
    t_colour                  w_paper;
    logic    [CellPixels-1:0] w_glyph;
    logic    [CountWidth:0]   w_pair_count;

    // Fold pens to base colours, build histogram and bright/plain counts
    always_comb begin
        w_count    = '0;
        w_n_bright = '0;
        w_n_plain  = '0;
        for (int p = 0; p < CellPixels; p++) begin
            w_colour[p] = i_pens[p][ColourWidth-1:0];
            w_count[w_colour[p]] = w_count[w_colour[p]] + 1'b1;
            if (w_colour[p] != BlackColour) begin
                if (i_pens[p][PenWidth-1]) begin
                    w_n_bright = w_n_bright + 1'b1;
                end else begin
                    w_n_plain = w_n_plain + 1'b1;
                end
            end
        end
    end

    // Pick most frequent colour, lowest index on a tie
    always_comb begin
        w_first = BlackColour;
        for (int a = 0; a < NumColours; a++) begin
            if (w_count[a] > w_count[w_first]) begin
                w_first = ColourWidth'(a);
            end
        end
    end

    // Pick second colour; a solid cell contrasts against white or black
    always_comb begin
        w_second = BlackColour;
        if (w_count[w_first] == FullCount) begin
            w_second = (w_first < SolidSplit) ? WhiteColour : BlackColour;
        end else begin
            for (int a = 0; a < NumColours; a++) begin
                if (w_count[a] > w_count[w_second] && ColourWidth'(a) != w_first) begin
                    w_second = ColourWidth'(a);
                end
            end
        end
    end

    // Move third colours to the nearer pick, ties to the second pick
    always_comb begin
        w_pair_count = {1'b0, w_count[w_first]} + {1'b0, w_count[w_second]};
        for (int p = 0; p < CellPixels; p++) begin
            w_moved[p] = w_colour[p];
            if (w_count[w_first] != FullCount && w_pair_count != {1'b0, FullCount} &&
                w_colour[p] != w_first && w_colour[p] != w_second) begin
                if (colour_distance(w_colour[p], w_second) >
                    colour_distance(w_colour[p], w_first)) begin
                    w_moved[p] = w_first;
                end else begin
                    w_moved[p] = w_second;
                end
            end
        end
    end

    // Order picks and mark ink pixels, top-left in the top bit
    always_comb begin
        if (w_first < w_second) begin
            w_paper = w_second;
            w_ink   = w_first;
        end else begin
            w_paper = w_first;
            w_ink   = w_second;
        end
        for (int p = 0; p < CellPixels; p++) begin
            w_glyph[CellPixels-1-p] = (w_moved[p] == w_ink);
        end
    end

    // Drop colour attributes in mono mode
    always_comb begin
        o_result.glyph_mask         = w_glyph;
        o_result.attributes_present = ~i_mono_mode;
        o_result.paper_colour       = i_mono_mode ? BlackColour : w_paper;
        o_result.ink_colour         = i_mono_mode ? BlackColour : w_ink;
        o_result.bright_flag        = ~i_mono_mode & (w_n_bright > w_n_plain);
    end

endmodule
